[sv/uvd_reply_bit_decoder_assert.svh]
// Assertion macros shared by the reply bit decoder modules.
`ifndef UVD_REPLY_BIT_DECODER_ASSERT_SVH
`define UVD_REPLY_BIT_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define UVD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define UVD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/uvd_pkg.sv]
// Package for the reply bit decoder: types, constants and pulse pair classification.
package uvd_pkg;

    localparam int AMP_W         = 8;
    localparam int SUM_W         = AMP_W + 1;
    localparam int CONF_BITS     = 16;
    localparam int VOTE_W        = CONF_BITS + 1;
    localparam int OUT_BITS      = 20;
    localparam int DATA_BITS_DEF = 20;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = AMP_W;
    localparam logic [VOTE_W-1:0] VOTE_MIN = VOTE_W'(19661);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DECODE_THR = 1'b0,
        REG_CHECK_THR  = 1'b1
    } t_reg_idx;

    // Decision for one pulse pair
    typedef enum logic [1:0] {
        CLS_ZERO = 2'd0,
        CLS_ONE  = 2'd1,
        CLS_NONE = 2'd2
    } t_cls;

    // What a lane hands to the merge stage
    typedef struct packed {
        logic                 done;
        t_cls                 dec_cls;
        t_cls                 chk_cls;
        logic [CONF_BITS-1:0] conf;
    } t_lane_stat;

    // Classify a pulse pair against a threshold; 0.6 and 0.4 ratios by cross-multiplication
    function automatic t_cls classify(input logic [AMP_W-1:0] l, input logic [AMP_W-1:0] r,
                                      input logic [AMP_W-1:0] t);
        logic             la;
        logic             ra;
        logic [SUM_W-1:0] s;
        logic [10:0]      r5;
        logic [10:0]      s3;
        logic [10:0]      s2;
        t_cls             res;
        la  = l > t;
        ra  = r > t;
        s   = {1'b0, l} + {1'b0, r};
        r5  = ({3'b0, r} << 2) + {3'b0, r};
        s3  = ({2'b0, s} << 1) + {2'b0, s};
        s2  = {1'b0, s, 1'b0};
        res = CLS_NONE;
        if (la && !ra) begin
            res = CLS_ZERO;
        end else if (!la && ra) begin
            res = CLS_ONE;
        end else if (la && ra) begin
            if (r5 > s3) begin
                res = CLS_ONE;
            end else if (r5 < s2) begin
                res = CLS_ZERO;
            end
        end
        return res;
    endfunction

endpackage

[sv/uvd_cell_if.sv]
// Input channel: one reply bit cell with both transmissions.
interface uvd_cell_if import uvd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [AMP_W-1:0] left_first;
    logic [AMP_W-1:0] right_first;
    logic [AMP_W-1:0] left_second;
    logic [AMP_W-1:0] right_second;

    modport source (output valid, output left_first, output right_first,
                    output left_second, output right_second, input ready);
    modport sink   (input valid, input left_first, input right_first,
                    input left_second, input right_second, output ready);
endinterface

[sv/uvd_word_if.sv]
// Output channel: decoded data word and error mask.
interface uvd_word_if import uvd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OUT_BITS-1:0] data_word;
    logic [OUT_BITS-1:0] fault_mask;

    modport source (output valid, output data_word, output fault_mask, input ready);
    modport sink   (input valid, input data_word, input fault_mask, output ready);
endinterface

[sv/uvd_reply_bit_decoder.sv]
// Top level of the reply bit decoder: configuration, sequencing, two lanes and merge.
//
// Usage:
//   i_cell carries one reply bit cell: left/right pulse amplitudes of the first
//   and of the repeated transmission. o_word carries the decoded data word and
//   the error mask once DATA_BITS cells have been taken.
//   Thresholds are written through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
// Timing:
//   Both transmissions are decoded side by side in two lanes; each lane's
//   confidence comes from a restoring divider giving one quotient bit per cycle.
//   Ready returns once both lanes are done and the merge step takes the cell, and
//   the word is registered onto o_word when its last cell is taken.
// Reset:
//   i_rst_n is synchronous, active low; it clears thresholds, cell count and
//   accumulators, and drops o_word.valid.
// Stall:
//   The result sits in an output register; cells keep flowing while it waits.
//   Only the last cell of the next word holds in the merge step until o_word
//   is taken, and i_cell.ready stays low meanwhile.
module uvd_reply_bit_decoder import uvd_pkg::*; #(
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    uvd_cell_if.sink              i_cell,
    uvd_word_if.source            o_word
);

`include "uvd_reply_bit_decoder_assert.svh"

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic [AMP_W-1:0] r_dec_thr;
    logic [AMP_W-1:0] r_chk_thr;

    logic             w_accept;
    logic             w_take;
    logic             w_take_ok;
    t_lane_stat       w_lane0;
    t_lane_stat       w_lane1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_thr <= '0;
            r_chk_thr <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_DECODE_THR: r_dec_thr <= i_cfg_data;
                REG_CHECK_THR:  r_chk_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign i_cell.ready = r_state == ST_IDLE;
    assign w_accept     = i_cell.valid && i_cell.ready;

    // Sequencer: accept, run the lanes, hand the result to the merge stage
    always_comb begin
        n_state = r_state;
        w_take  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_lane0.done) begin
                    if (w_take_ok) begin
                        w_take  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (w_take_ok) begin
                    w_take  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // First transmission
    uvd_lane u_lane0 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_left    (i_cell.left_first),
        .i_right   (i_cell.right_first),
        .i_dec_thr (r_dec_thr),
        .i_chk_thr (r_chk_thr),
        .o_stat    (w_lane0)
    );

    // Repeated transmission
    uvd_lane u_lane1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_left    (i_cell.left_second),
        .i_right   (i_cell.right_second),
        .i_dec_thr (r_dec_thr),
        .i_chk_thr (r_chk_thr),
        .o_stat    (w_lane1)
    );

    uvd_merge #(
        .DATA_BITS (DATA_BITS)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_take),
        .i_lane0   (w_lane0),
        .i_lane1   (w_lane1),
        .o_take_ok (w_take_ok),
        .o_word    (o_word)
    );

    `UVD_ASSERT_NXT(a_accept_runs, w_accept, r_state == ST_RUN, "accept did not start lanes")
    `UVD_ASSERT_IMP(a_lanes_sync, 1'b1, w_lane0.done == w_lane1.done, "lanes out of step")
    `UVD_ASSERT_IMP(a_done_in_run, w_lane0.done, r_state == ST_RUN, "lane done outside run")

endmodule

[sv/uvd_lane.sv]
// One transmission lane: pair classification and a bit-serial confidence divider.
module uvd_lane import uvd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [AMP_W-1:0] i_left,
    input  logic [AMP_W-1:0] i_right,
    input  logic [AMP_W-1:0] i_dec_thr,
    input  logic [AMP_W-1:0] i_chk_thr,
    output t_lane_stat       o_stat
);

    localparam int STEP_W = $clog2(CONF_BITS);

    logic                 r_busy;
    logic                 r_done;
    logic [STEP_W-1:0]    r_step;
    logic [SUM_W-1:0]     r_rem;
    logic [SUM_W-1:0]     r_den;
    logic [CONF_BITS-1:0] r_quo;
    t_cls                 r_dec_cls;
    t_cls                 r_chk_cls;

    t_cls                 w_dec_cls;
    logic                 w_both;
    logic [SUM_W-1:0]     w_sum;
    logic [SUM_W-1:0]     w_num;
    logic [SUM_W-1:0]     w_den;
    logic [SUM_W:0]       w_shift;
    logic [SUM_W:0]       w_diff;
    logic                 w_ge;
    logic                 w_last;

    // Numerator and divisor from the decode decision
    always_comb begin
        w_dec_cls = classify(i_left, i_right, i_dec_thr);
        w_both    = (i_left > i_dec_thr) && (i_right > i_dec_thr);
        w_sum     = {1'b0, i_left} + {1'b0, i_right};
        w_den     = w_both ? w_sum : SUM_W'(w_sum + SUM_W'(1));
        case (w_dec_cls)
            CLS_ONE:  w_num = {1'b0, i_right};
            CLS_ZERO: w_num = {1'b0, i_left};
            default:  w_num = '0;
        endcase
    end

    // One quotient bit per cycle; remainder stays below the divisor
    assign w_shift = {r_rem, 1'b0};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_last  = r_step == STEP_W'(CONF_BITS - 1);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= STEP_W'(r_step + STEP_W'(1));
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem     <= w_num;
            r_den     <= w_den;
            r_quo     <= '0;
            r_dec_cls <= w_dec_cls;
            r_chk_cls <= classify(i_left, i_right, i_chk_thr);
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[SUM_W-1:0] : w_shift[SUM_W-1:0];
            r_quo <= {r_quo[CONF_BITS-2:0], w_ge};
        end
    end

    assign o_stat.done    = r_done;
    assign o_stat.dec_cls = r_dec_cls;
    assign o_stat.chk_cls = r_chk_cls;
    assign o_stat.conf    = r_quo;

endmodule

[sv/uvd_merge.sv]
// Merge stage: votes over both lanes, gathers the word and holds the result.
module uvd_merge import uvd_pkg::*; #(
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  t_lane_stat i_lane0,
    input  t_lane_stat i_lane1,
    output logic       o_take_ok,
    uvd_word_if.source o_word
);

`include "uvd_reply_bit_decoder_assert.svh"

    localparam int CNT_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;

    logic [CNT_W-1:0]    r_cnt;
    logic [OUT_BITS-1:0] r_data_acc;
    logic [OUT_BITS-1:0] r_err_acc;
    logic                r_out_valid;
    logic [OUT_BITS-1:0] r_data_word;
    logic [OUT_BITS-1:0] r_fault_mask;

    logic [VOTE_W-1:0]   w_one;
    logic [VOTE_W-1:0]   w_zero;
    logic                w_data_bit;
    logic                w_err_bit;
    logic [OUT_BITS-1:0] w_bit;
    logic [OUT_BITS-1:0] n_data_acc;
    logic [OUT_BITS-1:0] n_err_acc;
    logic                n_out_valid;
    logic                w_last;

    // Confidence votes
    always_comb begin
        w_one  = '0;
        w_zero = '0;
        if (i_lane0.dec_cls == CLS_ONE) begin
            w_one = w_one + VOTE_W'(i_lane0.conf);
        end else if (i_lane0.dec_cls == CLS_ZERO) begin
            w_zero = w_zero + VOTE_W'(i_lane0.conf);
        end
        if (i_lane1.dec_cls == CLS_ONE) begin
            w_one = w_one + VOTE_W'(i_lane1.conf);
        end else if (i_lane1.dec_cls == CLS_ZERO) begin
            w_zero = w_zero + VOTE_W'(i_lane1.conf);
        end
    end

    assign w_data_bit = (w_one > w_zero) && (w_one >= VOTE_MIN);
    assign w_err_bit  = (i_lane0.chk_cls == CLS_NONE) || (i_lane1.chk_cls == CLS_NONE) ||
                        (i_lane0.chk_cls != i_lane1.chk_cls);

    // Cells past the output width shift out to nothing
    assign w_bit      = {{(OUT_BITS-1){1'b0}}, 1'b1} << r_cnt;
    assign n_data_acc = r_data_acc | (w_data_bit ? w_bit : '0);
    assign n_err_acc  = r_err_acc | (w_err_bit ? w_bit : '0);
    assign w_last     = r_cnt == CNT_W'(DATA_BITS - 1);

    // Last cell may go only when the result register is free
    assign o_take_ok = !w_last || !r_out_valid || o_word.ready;

    // Result register: freed by the sink, refilled by the last cell of a word
    assign n_out_valid = (r_out_valid && !o_word.ready) || (i_take && w_last);

    // Accumulators and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_data_acc  <= '0;
            r_err_acc   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_take) begin
                if (w_last) begin
                    r_cnt       <= '0;
                    r_data_acc  <= '0;
                    r_err_acc   <= '0;
                end else begin
                    r_cnt      <= CNT_W'(r_cnt + CNT_W'(1));
                    r_data_acc <= n_data_acc;
                    r_err_acc  <= n_err_acc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && w_last) begin
            r_data_word  <= n_data_acc;
            r_fault_mask <= n_err_acc;
        end
    end

    assign o_word.valid      = r_out_valid;
    assign o_word.data_word  = r_data_word;
    assign o_word.fault_mask = r_fault_mask;

    `UVD_ASSERT_IMP(a_emit_wraps, $rose(r_out_valid), r_cnt == '0, "result without count wrap")
    `UVD_ASSERT_IMP(a_emit_after_take, $rose(r_out_valid), $past(i_take), "result without a cell")
    `UVD_ASSERT_NXT(a_accum_clear, i_take && w_last, (r_data_acc == '0) && (r_err_acc == '0),
                    "accumulators not cleared after word")

endmodule

[tb/tb.sv]
// Self-checking testbench for the reply bit decoder: directed and random cells, checked per word.
module tb;
    import uvd_pkg::*;

    localparam int WORD_CELLS = DATA_BITS_DEF;
    localparam int DRAIN_CYC  = 40;
    localparam int QUIET_LO   = 4000;
    localparam int QUIET_HI   = 7000;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_WORDS = 4;

    typedef struct packed {
        logic [AMP_W-1:0] lf;
        logic [AMP_W-1:0] rf;
        logic [AMP_W-1:0] ls;
        logic [AMP_W-1:0] rs;
    } t_cell;

    typedef struct packed {
        logic [OUT_BITS-1:0] data;
        logic [OUT_BITS-1:0] err;
    } t_word;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    uvd_cell_if cell_if ();
    uvd_word_if word_if ();

    uvd_reply_bit_decoder i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cell     (cell_if),
        .o_word     (word_if)
    );

    // Cells waiting to go out, and words the decoder owes us
    t_cell pend_cells[$];
    t_word words_due[$];

    // Shadow of the block's thresholds and word accumulators
    logic [AMP_W-1:0]    dec_thr;
    logic [AMP_W-1:0]    chk_thr;
    int                  cur_cells;
    logic [OUT_BITS-1:0] data_bits_acc;
    logic [OUT_BITS-1:0] err_bits_acc;

    int cells_queued;
    int cells_taken;
    int mismatches;
    int cyc;
    bit cell_fired;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Classify one pulse pair and give its Q0.16 confidence
    function automatic t_cls pair_decision(input logic [AMP_W-1:0] l, input logic [AMP_W-1:0] r,
                                           input logic [AMP_W-1:0] thr,
                                           output logic [CONF_BITS-1:0] conf);
        int unsigned lv;
        int unsigned rv;
        int unsigned sum;
        bit          la;
        bit          ra;
        lv   = l;
        rv   = r;
        sum  = lv + rv;
        la   = l > thr;
        ra   = r > thr;
        conf = '0;
        if (la && !ra) begin
            conf = CONF_BITS'((lv << 16) / (sum + 1));
            return CLS_ZERO;
        end
        if (!la && ra) begin
            conf = CONF_BITS'((rv << 16) / (sum + 1));
            return CLS_ONE;
        end
        if (la && ra) begin
            // 0.6 / 0.4 split by cross-multiplication
            if (5 * rv > 3 * sum) begin
                conf = CONF_BITS'((rv << 16) / sum);
                return CLS_ONE;
            end
            if (5 * rv < 2 * sum) begin
                conf = CONF_BITS'((lv << 16) / sum);
                return CLS_ZERO;
            end
        end
        return CLS_NONE;
    endfunction

    // Fold one accepted cell into the word; queue the word when complete
    function automatic void decode_cell(input t_cell c);
        logic [CONF_BITS-1:0] c1;
        logic [CONF_BITS-1:0] c2;
        logic [VOTE_W-1:0]    yes_vote;
        logic [VOTE_W-1:0]    no_vote;
        t_cls                 v1;
        t_cls                 v2;
        bit                   dbit;
        bit                   ebit;
        t_word                w;
        yes_vote = '0;
        no_vote  = '0;
        v1 = pair_decision(c.lf, c.rf, dec_thr, c1);
        v2 = pair_decision(c.ls, c.rs, dec_thr, c2);
        if (v1 == CLS_ONE) yes_vote += VOTE_W'(c1);
        else if (v1 == CLS_ZERO) no_vote += VOTE_W'(c1);
        if (v2 == CLS_ONE) yes_vote += VOTE_W'(c2);
        else if (v2 == CLS_ZERO) no_vote += VOTE_W'(c2);
        dbit = (yes_vote > no_vote) && (yes_vote >= VOTE_MIN);

        // repetition check uses its own threshold
        v1 = pair_decision(c.lf, c.rf, chk_thr, c1);
        v2 = pair_decision(c.ls, c.rs, chk_thr, c2);
        ebit = (v1 == CLS_NONE) || (v2 == CLS_NONE) || (v1 != v2);

        if (cur_cells < OUT_BITS) begin
            if (dbit) data_bits_acc[cur_cells] = 1'b1;
            if (ebit) err_bits_acc[cur_cells] = 1'b1;
        end
        cur_cells++;
        if (cur_cells >= WORD_CELLS) begin
            w.data = data_bits_acc;
            w.err  = err_bits_acc;
            words_due = {words_due, w};
            cur_cells     = 0;
            data_bits_acc = '0;
            err_bits_acc  = '0;
        end
    endfunction

    function automatic logic [AMP_W-1:0] clip8(input int v);
        if (v < 0) return '0;
        if (v > 255) return 8'd255;
        return AMP_W'(v);
    endfunction

    // Pulse pair that reads as the given bit against thr (where thr allows)
    function automatic void make_pair(input bit one, input logic [AMP_W-1:0] thr,
                                      output logic [AMP_W-1:0] l, output logic [AMP_W-1:0] r);
        logic [AMP_W-1:0] hi;
        logic [AMP_W-1:0] lo;
        if (thr == 8'd255) begin
            hi = AMP_W'($urandom);
            lo = AMP_W'($urandom);
        end else begin
            hi = AMP_W'($urandom_range(255, int'(thr) + 1));
            if ($urandom_range(3, 0) != 0) lo = AMP_W'($urandom_range(int'(thr), 0));
            else lo = AMP_W'($urandom_range(int'(hi), 0));
        end
        if (one) begin
            l = lo;
            r = hi;
        end else begin
            l = hi;
            r = lo;
        end
    endfunction

    // One random cell: mostly clean repeated bits, then edge cases and noise
    function automatic t_cell make_cell();
        t_cell            c;
        int               mode;
        int               k;
        bit               b;
        logic [AMP_W-1:0] thr;
        logic [AMP_W-1:0] pa;
        logic [AMP_W-1:0] pb;
        mode = $urandom_range(9, 0);
        thr  = $urandom_range(1, 0) ? dec_thr : chk_thr;
        c    = t_cell'($urandom);
        if (mode <= 5) begin
            b = $urandom_range(1, 0);
            make_pair(b, thr, c.lf, c.rf);
            if ($urandom_range(4, 0) != 0) make_pair(b, thr, c.ls, c.rs);
            else make_pair(1'($urandom_range(1, 0)), thr, c.ls, c.rs);
        end else if (mode == 6) begin
            // amplitudes straddling the threshold
            c.lf = clip8(int'(thr) + $urandom_range(2, 0) - 1);
            c.rf = clip8(int'(thr) + $urandom_range(2, 0) - 1);
            c.ls = clip8(int'(thr) + $urandom_range(2, 0) - 1);
            c.rs = clip8(int'(thr) + $urandom_range(2, 0) - 1);
        end else if (mode == 7) begin
            // both pulses near the 0.6 / 0.4 split
            k  = $urandom_range(50, 1);
            pa = clip8(2 * k + $urandom_range(2, 0) - 1);
            pb = clip8(3 * k + $urandom_range(2, 0) - 1);
            if ($urandom_range(1, 0)) begin
                c.lf = pa;
                c.rf = pb;
            end else begin
                c.lf = pb;
                c.rf = pa;
            end
            if ($urandom_range(1, 0)) begin
                c.ls = c.lf;
                c.rs = c.rf;
            end else begin
                c.ls = c.rf;
                c.rs = c.lf;
            end
        end
        return c;
    endfunction

    task automatic push_cell(input t_cell c);
        pend_cells = {pend_cells, c};
        cells_queued++;
    endtask

    task automatic push_random_word();
        repeat (WORD_CELLS) push_cell(make_cell());
    endtask

    // Wait for all cells taken and all words seen, then let the pipe drain
    task automatic wait_drained();
        do @(negedge i_clk); while (cells_taken != cells_queued || words_due.size() != 0);
        repeat (DRAIN_CYC) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        if (idx == REG_DECODE_THR) dec_thr = val;
        else chk_thr = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Driver: cells out and result ready, changed on the falling edge
    always @(negedge i_clk) begin
        bit quiet;
        t_cell c;
        quiet = (cyc >= QUIET_LO) && (cyc < QUIET_HI);
        if (!i_rst_n) begin
            cell_if.valid <= 1'b0;
            word_if.ready <= 1'b0;
        end else begin
            word_if.ready <= quiet || ($urandom_range(99, 0) >= 34);
            if (!cell_if.valid || cell_fired) begin
                if (pend_cells.size() != 0 && (quiet || $urandom_range(99, 0) >= 34)) begin
                    c = pend_cells.pop_front();
                    cell_if.valid        <= 1'b1;
                    cell_if.left_first   <= c.lf;
                    cell_if.right_first  <= c.rf;
                    cell_if.left_second  <= c.ls;
                    cell_if.right_second <= c.rs;
                end else begin
                    cell_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: predict on accepted cells, check accepted words
    always @(posedge i_clk) begin
        t_cell c;
        t_word w;
        cyc++;
        cell_fired = i_rst_n && cell_if.valid && cell_if.ready;
        if (cell_fired) begin
            c.lf = cell_if.left_first;
            c.rf = cell_if.right_first;
            c.ls = cell_if.left_second;
            c.rs = cell_if.right_second;
            decode_cell(c);
            cells_taken++;
        end
        if (i_rst_n && word_if.valid && word_if.ready) begin
            if (words_due.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected word: data %05h err %05h",
                             word_if.data_word, word_if.fault_mask);
                mismatches++;
            end else begin
                w = words_due.pop_front();
                if (word_if.data_word !== w.data || word_if.fault_mask !== w.err) begin
                    if (mismatches < 10)
                        $display("word mismatch: data exp %05h got %05h, err exp %05h got %05h",
                                 w.data, word_if.data_word, w.err, word_if.fault_mask);
                    mismatches++;
                end
            end
        end
    end

    // Stimulus and phase sequencing
    initial begin
        logic [AMP_W-1:0] dec_list[NUM_PHASES];
        logic [AMP_W-1:0] chk_list[NUM_PHASES];
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = REG_DECODE_THR;
        i_cfg_data           = '0;
        cell_if.valid        = 1'b0;
        cell_if.left_first   = '0;
        cell_if.right_first  = '0;
        cell_if.left_second  = '0;
        cell_if.right_second = '0;
        word_if.ready        = 1'b0;
        dec_thr              = '0;
        chk_thr              = '0;
        cur_cells            = 0;
        data_bits_acc        = '0;
        err_bits_acc         = '0;
        cells_queued         = 0;
        cells_taken          = 0;
        mismatches           = 0;
        cyc                  = 0;
        cell_fired           = 1'b0;

        dec_list = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd40, 8'd0, 8'd0, 8'd0};
        chk_list = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd200, 8'd0, 8'd0, 8'd0};
        for (int p = 5; p < NUM_PHASES; p++) begin
            dec_list[p] = AMP_W'($urandom);
            chk_list[p] = AMP_W'($urandom);
        end

        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed word at reset thresholds
        push_cell('{8'd0,   8'd0,   8'd0,   8'd0});    // nothing active
        push_cell('{8'd255, 8'd255, 8'd255, 8'd255});  // full scale, balanced
        push_cell('{8'd0,   8'd255, 8'd0,   8'd255});  // clean one
        push_cell('{8'd255, 8'd0,   8'd255, 8'd0});    // clean zero
        push_cell('{8'd0,   8'd255, 8'd255, 8'd0});    // disagree, equal votes
        push_cell('{8'd2,   8'd3,   8'd3,   8'd2});    // exactly on 0.6 and 0.4
        push_cell('{8'd39,  8'd61,  8'd61,  8'd39});   // just past the split, opposite
        push_cell('{8'd40,  8'd61,  8'd40,  8'd61});   // just past 0.6
        push_cell('{8'd1,   8'd0,   8'd0,   8'd1});    // smallest pulses
        push_cell('{8'd0,   8'd1,   8'd0,   8'd0});    // one side undecided
        push_cell('{8'd128, 8'd127, 8'd127, 8'd128});
        push_cell('{8'd255, 8'd1,   8'd1,   8'd255});
        push_cell('{8'd170, 8'd85,  8'd85,  8'd170});
        push_cell('{8'd0,   8'd255, 8'd0,   8'd200});
        push_cell('{8'd255, 8'd254, 8'd0,   8'd0});
        push_cell('{8'd1,   8'd1,   8'd1,   8'd1});
        push_cell('{8'd100, 8'd0,   8'd0,   8'd100});  // tie between votes
        push_cell('{8'd100, 8'd0,   8'd0,   8'd101});  // one wins by a hair
        push_cell('{8'd0,   8'd0,   8'd0,   8'd255});
        push_cell('{8'd128, 8'd128, 8'd64,  8'd64});
        wait_drained();

        // Random words across threshold settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_reg(REG_DECODE_THR, dec_list[p]);
            write_reg(REG_CHECK_THR, chk_list[p]);
            repeat (PHASE_WORDS) push_random_word();
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
